### rtl/core/wpcm_pkg.sv
// ----------------------------------------------------------------------------
// wpcm_pkg
// Types and constants shared by the RIFF/WAVE PCM chunk parser.
// ----------------------------------------------------------------------------
package wpcm_pkg;

  localparam logic [1:0] KIND_FMT  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NOT_RIFF = 3'd1;
  localparam logic [2:0] ERR_NOT_WAVE = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM  = 3'd3;
  localparam logic [2:0] ERR_NO_DATA  = 3'd4;
  localparam logic [2:0] ERR_TRUNC    = 3'd5;
  localparam logic [2:0] ERR_SHORT    = 3'd6;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [15:0] PCM_TAG  = 16'h0001;
  localparam logic [31:0] FMT_MIN  = 32'd16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic        last_data;
    logic [2:0]  error_code;
  } out_t;

endpackage

### rtl/core/riff_wave_pcm_chunk_parser.sv
// ----------------------------------------------------------------------------
// riff_wave_pcm_chunk_parser
// Byte-serial RIFF/WAVE PCM parser: format info, data bytes and error results.
// ----------------------------------------------------------------------------
//  Channel | Handshake                     | Payload
//  in      | in_valid_i / in_ready_o       | in_data_i  (wpcm_pkg::in_t)
//  out     | out_valid_o / out_ready_i     | out_data_o (wpcm_pkg::out_t)
//
//  One byte per cycle; a byte with two results (payload then end-of-file error)
//  holds off the next byte while the second result is queued.
//  A result reaches the output through the queue and then the output register
//  after the byte's transfer.
//  Reset is asynchronous and active low; the parser also rearms after each end of file.
//  Otherwise input stalls only when the two-entry result queue is full.
// ----------------------------------------------------------------------------
module riff_wave_pcm_chunk_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wpcm_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wpcm_pkg::out_t  out_data_o
);

  logic           f_valid, f_ready;
  wpcm_pkg::out_t f_ent;
  logic           q_valid, q_ready;
  wpcm_pkg::out_t q_ent;

  wpcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .ent_valid_o (f_valid),
    .ent_ready_i (f_ready),
    .ent_o       (f_ent)
  );

  wpcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_ent),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_ent)
  );

  wpcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_valid),
    .ent_ready_o (q_ready),
    .ent_i       (q_ent),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_in_blocked_by_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !f_ready |-> !in_ready_o)
    else $error("input taken while result queue is full");

  a_data_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == wpcm_pkg::KIND_DATA) |->
      (out_data_o.channels == 16'd0 && out_data_o.sample_rate == 32'd0 &&
       out_data_o.error_code == wpcm_pkg::ERR_NONE))
    else $error("data result carries format or error fields");

  a_err_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == wpcm_pkg::KIND_ERR) |->
      (out_data_o.error_code != wpcm_pkg::ERR_NONE && !out_data_o.last_data))
    else $error("error result without a code");

  a_queue_feeds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !out_valid_o) |=> out_valid_o)
    else $error("queued result not moved to the output register");

endmodule

### rtl/core/wpcm_front.sv
// ----------------------------------------------------------------------------
// wpcm_front
// Byte parser: tracks the RIFF/WAVE structure and issues raw result entries.
// ----------------------------------------------------------------------------
module wpcm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wpcm_pkg::in_t   in_data_i,
  output logic            ent_valid_o,
  input  logic            ent_ready_i,
  output wpcm_pkg::out_t  ent_o
);

  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_RSIZE = 3'd1;
  localparam logic [2:0] PH_WAVE  = 3'd2;
  localparam logic [2:0] PH_HDR   = 3'd3;
  localparam logic [2:0] PH_FMT   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;
  localparam logic [2:0] PH_IDLE  = 3'd7;

  function automatic logic [31:0] padded(input logic [31:0] len);
    padded = len + {31'd0, len[0] & ~(&len)};
  endfunction

  logic [2:0]  ph_q, ph_d;
  logic [3:0]  bc_q, bc_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  ftag_q, ftag_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        pend_q, pend_d;
  logic [2:0]  pend_code_q, pend_code_d;

  logic [7:0]  b;
  logic        eof;
  logic        accept;
  logic        clean, errored, r0_v, eof_v;
  logic [1:0]  r0_kind;
  logic [2:0]  r0_code, eof_code;
  logic [31:0] tag_sh, len_sh, hdr_pad;
  wpcm_pkg::out_t r0_ent;

  assign b          = in_data_i.in_byte;
  assign eof        = in_data_i.end_of_file;
  assign in_ready_o = ~pend_q & ent_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    ph_d    = ph_q;
    bc_d    = bc_q;
    tag_d   = tag_q;
    len_d   = len_q;
    ftag_d  = ftag_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    clean   = 1'b0;
    errored = 1'b0;
    r0_v    = 1'b0;
    r0_kind = wpcm_pkg::KIND_FMT;
    r0_code = wpcm_pkg::ERR_NONE;
    tag_sh  = {tag_q[23:0], b};
    len_sh  = {b, len_q[31:8]};
    hdr_pad = padded(len_sh);

    case (ph_q)
      PH_RIFF, PH_WAVE: begin
        tag_d = tag_sh;
        bc_d  = bc_q + 4'd1;
        if (bc_q >= 4'd3) begin
          bc_d = 4'd0;
          if (ph_q == PH_RIFF) begin
            if (tag_sh != wpcm_pkg::TAG_RIFF) begin
              errored = 1'b1;
              r0_code = wpcm_pkg::ERR_NOT_RIFF;
            end else begin
              ph_d = PH_RSIZE;
            end
          end else if (tag_sh != wpcm_pkg::TAG_WAVE) begin
            errored = 1'b1;
            r0_code = wpcm_pkg::ERR_NOT_WAVE;
          end else begin
            ph_d  = PH_HDR;
            clean = 1'b1;
          end
        end
      end
      PH_RSIZE: begin
        bc_d = bc_q + 4'd1;
        if (bc_q >= 4'd3) begin
          bc_d = 4'd0;
          ph_d = PH_WAVE;
        end
      end
      PH_HDR: begin
        if (bc_q < 4'd4) begin
          tag_d = tag_sh;
        end else begin
          len_d = len_sh;
        end
        bc_d = bc_q + 4'd1;
        if (bc_q >= 4'd7) begin
          bc_d = 4'd0;
          if (tag_q == wpcm_pkg::TAG_FMT) begin
            if (len_sh < wpcm_pkg::FMT_MIN) begin
              errored = 1'b1;
              r0_code = wpcm_pkg::ERR_SHORT;
            end else begin
              len_d = hdr_pad;
              ph_d  = PH_FMT;
            end
          end else if (tag_q == wpcm_pkg::TAG_DATA) begin
            ph_d = (len_sh == 32'd0) ? PH_IDLE : PH_DATA;
          end else begin
            len_d = hdr_pad;
            if (hdr_pad == 32'd0) begin
              clean = 1'b1;
            end else begin
              ph_d = PH_SKIP;
            end
          end
        end
      end
      PH_FMT: begin
        case (bc_q)
          4'd0: ftag_d = b;
          4'd1: begin
            if ({b, ftag_q} != wpcm_pkg::PCM_TAG) begin
              errored = 1'b1;
              r0_code = wpcm_pkg::ERR_NOT_PCM;
            end
          end
          4'd2: chan_d = {8'd0, b};
          4'd3: chan_d = {b, chan_q[7:0]};
          4'd4, 4'd5, 4'd6, 4'd7: rate_d = {b, rate_q[31:8]};
          4'd14: bits_d = {8'd0, b};
          4'd15: bits_d = {b, bits_q[7:0]};
          default: ;
        endcase
        if (!errored) begin
          bc_d = bc_q + 4'd1;
          if (bc_q == 4'd15) begin
            bc_d    = 4'd0;
            r0_v    = 1'b1;
            r0_kind = wpcm_pkg::KIND_FMT;
            len_d   = len_q - wpcm_pkg::FMT_MIN;
            if (len_q == wpcm_pkg::FMT_MIN) begin
              ph_d  = PH_HDR;
              clean = 1'b1;
            end else begin
              ph_d = PH_SKIP;
            end
          end
        end
      end
      PH_DATA: begin
        r0_v    = 1'b1;
        r0_kind = wpcm_pkg::KIND_DATA;
        len_d   = len_q - 32'd1;
        if (len_q == 32'd1) begin
          ph_d = PH_IDLE;
        end
      end
      PH_SKIP: begin
        len_d = len_q - 32'd1;
        if (len_q == 32'd1) begin
          ph_d  = PH_HDR;
          bc_d  = 4'd0;
          clean = 1'b1;
        end
      end
      default: ;
    endcase

    if (errored) begin
      r0_v    = 1'b1;
      r0_kind = wpcm_pkg::KIND_ERR;
      ph_d    = PH_IDLE;
      bc_d    = 4'd0;
    end

    r0_ent.kind            = r0_kind;
    r0_ent.data_byte       = b;
    r0_ent.channels        = chan_d;
    r0_ent.sample_rate     = rate_d;
    r0_ent.bits_per_sample = bits_d;
    r0_ent.last_data       = (len_q == 32'd1);
    r0_ent.error_code      = r0_code;

    eof_v    = eof & (ph_d != PH_IDLE);
    eof_code = ((ph_d == PH_HDR) && clean) ? wpcm_pkg::ERR_NO_DATA : wpcm_pkg::ERR_TRUNC;

    if (eof) begin
      ph_d   = PH_RIFF;
      bc_d   = 4'd0;
      tag_d  = 32'd0;
      len_d  = 32'd0;
      ftag_d = 8'd0;
      chan_d = 16'd0;
      rate_d = 32'd0;
      bits_d = 16'd0;
    end

    pend_d      = pend_q;
    pend_code_d = pend_code_q;
    ent_o       = r0_ent;
    ent_valid_o = 1'b0;
    if (pend_q) begin
      ent_valid_o           = 1'b1;
      ent_o                 = '0;
      ent_o.kind            = wpcm_pkg::KIND_ERR;
      ent_o.error_code      = pend_code_q;
      if (ent_ready_i) begin
        pend_d = 1'b0;
      end
    end else begin
      ent_valid_o = in_valid_i & (r0_v | eof_v);
      if (!r0_v) begin
        ent_o            = '0;
        ent_o.kind       = wpcm_pkg::KIND_ERR;
        ent_o.error_code = eof_code;
      end
      if (accept && r0_v && eof_v) begin
        pend_d      = 1'b1;
        pend_code_d = eof_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_RIFF;
      bc_q        <= 4'd0;
      tag_q       <= 32'd0;
      len_q       <= 32'd0;
      ftag_q      <= 8'd0;
      chan_q      <= 16'd0;
      rate_q      <= 32'd0;
      bits_q      <= 16'd0;
      pend_q      <= 1'b0;
      pend_code_q <= wpcm_pkg::ERR_NONE;
    end else begin
      pend_q      <= pend_d;
      pend_code_q <= pend_code_d;
      if (accept) begin
        ph_q   <= ph_d;
        bc_q   <= bc_d;
        tag_q  <= tag_d;
        len_q  <= len_d;
        ftag_q <= ftag_d;
        chan_q <= chan_d;
        rate_q <= rate_d;
        bits_q <= bits_d;
      end
    end
  end

endmodule

### rtl/core/wpcm_queue.sv
// ----------------------------------------------------------------------------
// wpcm_queue
// Short FIFO of result entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module wpcm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  wpcm_pkg::out_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output wpcm_pkg::out_t  pop_data_o
);

  localparam logic [wpcm_pkg::QPTR_W-1:0] LastPtr = wpcm_pkg::QPTR_W'(wpcm_pkg::QUEUE_DEPTH - 1);
  localparam logic [wpcm_pkg::QPTR_W:0]   Full    = (wpcm_pkg::QPTR_W+1)'(wpcm_pkg::QUEUE_DEPTH);
  localparam logic [wpcm_pkg::QPTR_W:0]   CntOne  = (wpcm_pkg::QPTR_W+1)'(1);

  wpcm_pkg::out_t              mem_q [wpcm_pkg::QUEUE_DEPTH];
  logic [wpcm_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [wpcm_pkg::QPTR_W:0]   cnt_q, cnt_d;
  logic                        push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntOne;
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
    end
  end

endmodule

### rtl/core/wpcm_back.sv
// ----------------------------------------------------------------------------
// wpcm_back
// Output stage: clears fields that do not apply to the kind and registers the result.
// ----------------------------------------------------------------------------
module wpcm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ent_valid_i,
  output logic            ent_ready_o,
  input  wpcm_pkg::out_t  ent_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wpcm_pkg::out_t  out_data_o
);

  logic           out_valid_q;
  wpcm_pkg::out_t out_q, out_d;
  logic           is_fmt, is_data, is_err;

  assign is_fmt      = (ent_i.kind == wpcm_pkg::KIND_FMT);
  assign is_data     = (ent_i.kind == wpcm_pkg::KIND_DATA);
  assign is_err      = (ent_i.kind == wpcm_pkg::KIND_ERR);
  assign ent_ready_o = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_d.kind            = ent_i.kind;
    out_d.data_byte       = is_data ? ent_i.data_byte : 8'd0;
    out_d.channels        = is_fmt ? ent_i.channels : 16'd0;
    out_d.sample_rate     = is_fmt ? ent_i.sample_rate : 32'd0;
    out_d.bits_per_sample = is_fmt ? ent_i.bits_per_sample : 16'd0;
    out_d.last_data       = is_data & ent_i.last_data;
    out_d.error_code      = is_err ? ent_i.error_code : wpcm_pkg::ERR_NONE;
  end

  always_ff @(posedge clk_i) begin
    if (ent_valid_i && ent_ready_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ent_ready_o) begin
      out_valid_q <= ent_valid_i;
    end
  end

endmodule

### bench/riff_wave_pcm_chunk_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riff_wave_pcm_chunk_parser_test
// Self-checking bench for the byte-serial RIFF/WAVE PCM parser. A scoreboard
// tracks the parse of every transferred byte and predicts the format, data
// and error results, which are compared field by field as they leave the
// block. Directed files hit the tag, fmt, padding and end-of-file corner
// cases, then random well-formed, broken and noise files follow, with random
// gaps on both handshakes.
// ----------------------------------------------------------------------------
module riff_wave_pcm_chunk_parser_test;

  localparam int unsigned BYTE_TARGET  = 2000;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
  localparam logic [31:0] TAG_WAVF = 32'h5741_5646;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [31:0] TAG_JUNK = 32'h4A55_4E4B;

  typedef enum logic [2:0] {
    ST_RIFF_TAG, ST_RIFF_SIZE, ST_WAVE_TAG, ST_CHUNK_HDR,
    ST_FMT_BODY, ST_DATA_BODY, ST_SKIP_BODY, ST_IDLE
  } parse_state_e;

  class wav_scoreboard;
    parse_state_e   state;
    logic [31:0]    field_idx;
    logic [31:0]    tag_acc;
    logic [31:0]    chunk_left;
    logic [31:0]    rate_acc;
    logic [15:0]    fmt_code;
    logic [15:0]    chan_acc;
    logic [15:0]    bits_acc;
    wpcm_pkg::out_t pending[$];
    int unsigned    fails;
    int unsigned    n_fmt;
    int unsigned    n_data;
    int unsigned    n_err;

    function new();
      reset_state();
      fails  = 0;
      n_fmt  = 0;
      n_data = 0;
      n_err  = 0;
    endfunction

    function void reset_state();
      state      = ST_RIFF_TAG;
      field_idx  = '0;
      tag_acc    = '0;
      chunk_left = '0;
      rate_acc   = '0;
      fmt_code   = '0;
      chan_acc   = '0;
      bits_acc   = '0;
    endfunction

    function logic [31:0] with_pad(logic [31:0] len);
      if (len[0] && len != 32'hFFFF_FFFF) return len + 32'd1;
      return len;
    endfunction

    function void expect_result(logic [1:0] kind, logic [7:0] db, logic last,
                                logic [2:0] code);
      wpcm_pkg::out_t r;
      r = '0;
      r.kind       = kind;
      r.data_byte  = db;
      r.last_data  = last;
      r.error_code = code;
      if (kind == wpcm_pkg::KIND_FMT) begin
        r.channels        = chan_acc;
        r.sample_rate     = rate_acc;
        r.bits_per_sample = bits_acc;
      end
      pending.push_back(r);
    endfunction

    // one transferred byte of the file
    function void note_byte(wpcm_pkg::in_t x);
      bit clean;
      bit bad;
      clean = 1'b0;
      bad   = 1'b0;
      case (state)
        ST_RIFF_TAG, ST_WAVE_TAG: begin
          tag_acc = {tag_acc[23:0], x.in_byte};
          field_idx++;
          if (field_idx >= 4) begin
            field_idx = '0;
            if (state == ST_RIFF_TAG) begin
              if (tag_acc != wpcm_pkg::TAG_RIFF) begin
                expect_result(wpcm_pkg::KIND_ERR, 8'd0, 1'b0, wpcm_pkg::ERR_NOT_RIFF);
                bad = 1'b1;
              end else begin
                state = ST_RIFF_SIZE;
              end
            end else if (tag_acc != wpcm_pkg::TAG_WAVE) begin
              expect_result(wpcm_pkg::KIND_ERR, 8'd0, 1'b0, wpcm_pkg::ERR_NOT_WAVE);
              bad = 1'b1;
            end else begin
              state = ST_CHUNK_HDR;
              clean = 1'b1;
            end
          end
        end
        ST_RIFF_SIZE: begin
          field_idx++;
          if (field_idx >= 4) begin
            field_idx = '0;
            state     = ST_WAVE_TAG;
          end
        end
        ST_CHUNK_HDR: begin
          if (field_idx < 4) tag_acc = {tag_acc[23:0], x.in_byte};
          else chunk_left = {x.in_byte, chunk_left[31:8]};
          field_idx++;
          if (field_idx >= 8) begin
            field_idx = '0;
            if (tag_acc == wpcm_pkg::TAG_FMT) begin
              if (chunk_left < wpcm_pkg::FMT_MIN) begin
                expect_result(wpcm_pkg::KIND_ERR, 8'd0, 1'b0, wpcm_pkg::ERR_SHORT);
                bad = 1'b1;
              end else begin
                chunk_left = with_pad(chunk_left);
                state      = ST_FMT_BODY;
              end
            end else if (tag_acc == wpcm_pkg::TAG_DATA) begin
              state = (chunk_left == 0) ? ST_IDLE : ST_DATA_BODY;
            end else begin
              chunk_left = with_pad(chunk_left);
              if (chunk_left == 0) clean = 1'b1;
              else state = ST_SKIP_BODY;
            end
          end
        end
        ST_FMT_BODY: begin
          case (field_idx)
            0: fmt_code = {8'd0, x.in_byte};
            1: begin
              fmt_code[15:8] = x.in_byte;
              if (fmt_code != wpcm_pkg::PCM_TAG) begin
                expect_result(wpcm_pkg::KIND_ERR, 8'd0, 1'b0, wpcm_pkg::ERR_NOT_PCM);
                bad = 1'b1;
              end
            end
            2: chan_acc = {8'd0, x.in_byte};
            3: chan_acc[15:8] = x.in_byte;
            4, 5, 6, 7: rate_acc = {x.in_byte, rate_acc[31:8]};
            14: bits_acc = {8'd0, x.in_byte};
            15: bits_acc[15:8] = x.in_byte;
            default: ;
          endcase
          if (!bad) begin
            field_idx++;
            if (field_idx >= 16) begin
              field_idx = '0;
              expect_result(wpcm_pkg::KIND_FMT, 8'd0, 1'b0, wpcm_pkg::ERR_NONE);
              chunk_left -= wpcm_pkg::FMT_MIN;
              if (chunk_left == 0) begin
                state = ST_CHUNK_HDR;
                clean = 1'b1;
              end else begin
                state = ST_SKIP_BODY;
              end
            end
          end
        end
        ST_DATA_BODY: begin
          expect_result(wpcm_pkg::KIND_DATA, x.in_byte, chunk_left == 32'd1,
                        wpcm_pkg::ERR_NONE);
          chunk_left--;
          if (chunk_left == 0) state = ST_IDLE;
        end
        ST_SKIP_BODY: begin
          chunk_left--;
          if (chunk_left == 0) begin
            state     = ST_CHUNK_HDR;
            field_idx = '0;
            clean     = 1'b1;
          end
        end
        default: ;
      endcase
      if (bad) begin
        state     = ST_IDLE;
        field_idx = '0;
      end
      if (x.end_of_file) begin
        if (state != ST_IDLE)
          expect_result(wpcm_pkg::KIND_ERR, 8'd0, 1'b0,
                        (state == ST_CHUNK_HDR && clean) ? wpcm_pkg::ERR_NO_DATA
                                                         : wpcm_pkg::ERR_TRUNC);
        reset_state();
      end
    endfunction

    function void field_cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(wpcm_pkg::out_t got);
      wpcm_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("result with none pending: kind %0d code %0d", got.kind, got.error_code);
        fails++;
        return;
      end
      want = pending.pop_front();
      field_cmp("kind", 32'(want.kind), 32'(got.kind));
      field_cmp("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      field_cmp("channels", 32'(want.channels), 32'(got.channels));
      field_cmp("sample_rate", want.sample_rate, got.sample_rate);
      field_cmp("bits_per_sample", 32'(want.bits_per_sample), 32'(got.bits_per_sample));
      field_cmp("last_data", 32'(want.last_data), 32'(got.last_data));
      field_cmp("error_code", 32'(want.error_code), 32'(got.error_code));
      case (want.kind)
        wpcm_pkg::KIND_FMT:  n_fmt++;
        wpcm_pkg::KIND_DATA: n_data++;
        default:             n_err++;
      endcase
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  wpcm_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  wpcm_pkg::out_t out_data;

  wav_scoreboard sb;
  logic [7:0]    file_q[$];
  bit            in_calm   = 1'b0;
  bit            out_calm  = 1'b0;
  int unsigned   files_sent = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   idle_cycles = 0;

  riff_wave_pcm_chunk_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
          $display("** riff_wave_pcm_chunk_parser: FAILED **");
          $finish;
        end
      end
    end
  end

  // file builders
  function void put_le(logic [31:0] v, int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function void put_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_q.push_back(t[8*i +: 8]);
  endfunction

  function void put_random(int unsigned n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function void put_head();
    put_tag(wpcm_pkg::TAG_RIFF);
    put_le($urandom, 4);
    put_tag(wpcm_pkg::TAG_WAVE);
  endfunction

  // bodies longer than 64 bytes are left to truncation
  function void put_chunk(logic [31:0] id, logic [31:0] size);
    put_tag(id);
    put_le(size, 4);
    if (size <= 64) begin
      put_random(size);
      if (size[0]) put_random(1);
    end
  endfunction

  function void put_fmt(logic [31:0] size, logic [15:0] code, logic [15:0] ch,
                        logic [31:0] rate, logic [15:0] bits);
    put_tag(wpcm_pkg::TAG_FMT);
    put_le(size, 4);
    if (size < wpcm_pkg::FMT_MIN) begin
      put_random(size);
    end else begin
      put_le({16'd0, code}, 2);
      put_le({16'd0, ch}, 2);
      put_le(rate, 4);
      put_random(6);
      put_le({16'd0, bits}, 2);
      if (size <= 64) begin
        put_random(size - wpcm_pkg::FMT_MIN);
        if (size[0]) put_random(1);
      end
    end
  endfunction

  function logic [31:0] mangle(logic [31:0] t);
    return t ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  function logic [31:0] other_id();
    logic [31:0] id;
    if ($urandom_range(0, 2) == 0)
      id = mangle($urandom_range(0, 1) ? wpcm_pkg::TAG_FMT : wpcm_pkg::TAG_DATA);
    else id = $urandom;
    if (id == wpcm_pkg::TAG_FMT || id == wpcm_pkg::TAG_DATA) id ^= 32'h100;
    return id;
  endfunction

  function void build_random_file();
    int unsigned pick;
    int unsigned r;
    int unsigned keep;
    logic [31:0] size;
    logic [15:0] code;
    file_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      put_random($urandom_range(1, 12));
      return;
    end
    put_tag(pick < 12 ? mangle(wpcm_pkg::TAG_RIFF) : wpcm_pkg::TAG_RIFF);
    put_le($urandom, 4);
    put_tag(pick >= 12 && pick < 15 ? mangle(wpcm_pkg::TAG_WAVE) : wpcm_pkg::TAG_WAVE);
    repeat ($urandom_range(0, 2)) put_chunk(other_id(), $urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 5) size = $urandom_range(0, 15);
    else size = 16 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    code = wpcm_pkg::PCM_TAG;
    if (r >= 5 && r < 10) begin
      code = 16'($urandom);
      if (code == wpcm_pkg::PCM_TAG) code = 16'h8001;
    end
    put_fmt(size, code, $urandom_range(0, 1) ? 16'($urandom_range(1, 8)) : 16'($urandom),
            $urandom, 16'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1))
        put_fmt(16, wpcm_pkg::PCM_TAG, 16'($urandom), $urandom, 16'($urandom));
      else put_chunk(other_id(), $urandom_range(0, 5));
    end
    if ($urandom_range(0, 19) != 0)
      put_chunk(wpcm_pkg::TAG_DATA, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24));
    if ($urandom_range(0, 2) == 0) put_random($urandom_range(1, 5));
    if ($urandom_range(0, 3) == 0) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
  endfunction

  // drivers
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_data.in_byte     <= b;
    in_data.end_of_file <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(in_data);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic run_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // end of file on the first byte
    file_q.delete();
    file_q.push_back(8'hFF);
    run_file();
    // bad RIFF tag, rest ignored
    file_q.delete();
    put_tag(TAG_RIFX);
    put_random(2);
    run_file();
    // bad WAVE tag on the last byte: only the tag error
    file_q.delete();
    put_tag(wpcm_pkg::TAG_RIFF);
    put_le(32'hFFFF_FFFF, 4);
    put_tag(TAG_WAVF);
    run_file();
    // ends right after WAVE
    file_q.delete();
    put_head();
    run_file();
    // clean file with trailing bytes
    file_q.delete();
    put_head();
    put_fmt(16, wpcm_pkg::PCM_TAG, 16'd2, 32'd44100, 16'd16);
    put_chunk(wpcm_pkg::TAG_DATA, 4);
    put_random(3);
    run_file();
    // short fmt
    file_q.delete();
    put_head();
    put_fmt(15, wpcm_pkg::PCM_TAG, 16'd1, 32'd8000, 16'd8);
    run_file();
    // not PCM
    file_q.delete();
    put_head();
    put_fmt(16, 16'h0003, 16'd1, 32'd48000, 16'd32);
    run_file();
    // padding, empty chunk, repeated fmt at both extremes, empty data
    file_q.delete();
    put_head();
    put_chunk(TAG_LIST, 3);
    put_chunk(TAG_JUNK, 0);
    put_fmt(17, wpcm_pkg::PCM_TAG, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_fmt(16, wpcm_pkg::PCM_TAG, 16'h0000, 32'h0000_0000, 16'h0000);
    put_chunk(wpcm_pkg::TAG_DATA, 0);
    put_random(2);
    run_file();
    // ends after a whole chunk, no data
    file_q.delete();
    put_head();
    put_fmt(18, wpcm_pkg::PCM_TAG, 16'd2, 32'd22050, 16'd8);
    put_chunk(TAG_LIST, 5);
    run_file();
    // truncated inside data
    file_q.delete();
    put_head();
    put_fmt(16, wpcm_pkg::PCM_TAG, 16'd1, 32'd11025, 16'd16);
    put_chunk(wpcm_pkg::TAG_DATA, 10);
    repeat (7) void'(file_q.pop_back());
    run_file();
    // saturated unknown chunk size
    file_q.delete();
    put_head();
    put_chunk(TAG_LIST, 32'hFFFF_FFFF);
    put_random(5);
    run_file();
    // saturated fmt size
    file_q.delete();
    put_head();
    put_fmt(32'hFFFF_FFFF, wpcm_pkg::PCM_TAG, 16'd6, 32'd96000, 16'd24);
    put_random(3);
    run_file();
    // ends inside a chunk header
    file_q.delete();
    put_head();
    put_tag(wpcm_pkg::TAG_FMT);
    put_random(2);
    run_file();
    // huge data chunk cut short
    file_q.delete();
    put_head();
    put_fmt(16, wpcm_pkg::PCM_TAG, 16'd2, 32'd44100, 16'd16);
    put_chunk(wpcm_pkg::TAG_DATA, 32'hFFFF_FFFF);
    put_random(4);
    run_file();
    // all zero bytes
    file_q.delete();
    repeat (8) file_q.push_back(8'h00);
    run_file();
    drain();

    while (bytes_sent < BYTE_TARGET) begin
      build_random_file();
      if ($urandom_range(0, 3) == 0) in_calm = !in_calm;
      run_file();
      if (files_sent % 10 == 0) drain();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d files, %0d bytes; checked %0d format, %0d data, %0d error results",
             files_sent, bytes_sent, sb.n_fmt, sb.n_data, sb.n_err);
    $display("mismatches or unexpected results: %0d", sb.fails);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("** riff_wave_pcm_chunk_parser: PASSED **");
    end else begin
      $display("** riff_wave_pcm_chunk_parser: FAILED **");
    end
    $finish;
  end

endmodule
